// ===== hw/rtl/wto_pkg.sv =====
// Shared types, constants and the quarter-sine table builder for the
// wavetable oscillator. No dependencies.
`timescale 1ns / 1ps

package wto_pkg;

  // Default parameter values.
  localparam int PHASE_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Field widths.
  localparam int ACTION_W    = 2;
  localparam int TUNING_W    = 32;
  localparam int MIX_W       = 16;
  localparam int IN_DATA_W   = TUNING_W + MIX_W;
  localparam int OUT_W       = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int GAIN_W      = 16;
  localparam int ENV_W       = 17;

  localparam logic [ENV_W-1:0]  ENV_ONE    = 17'h10000;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;
  localparam logic [ENV_W-1:0]  RAMP_RESET = 17'd1365;

  // Quarter-wave sine table geometry.
  localparam int SINE_TABLE_BITS = 10;
  localparam int QUARTER_LEN     = 1 << (SINE_TABLE_BITS - 2);
  localparam int SINE_ADDR_BITS  = SINE_TABLE_BITS - 1;
  localparam int SINE_DEPTH      = QUARTER_LEN + 1;
  localparam logic [SINE_ADDR_BITS-1:0] QUARTER_IDX = SINE_ADDR_BITS'(QUARTER_LEN);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Taylor divisors (2k)(2k+1), k = 1..12.
  localparam logic [12:1][9:0] TAYLOR_DIV = {
    10'd600, 10'd506, 10'd420, 10'd342, 10'd272, 10'd210,
    10'd156, 10'd110, 10'd72,  10'd42,  10'd20,  10'd6
  };

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_NOTE_ON  = 2'd1,
    ACT_NOTE_OFF = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_SQUARE = 2'd1,
    SHAPE_SAW    = 2'd2,
    SHAPE_TRI    = 2'd3
  } shape_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WAVE_SHAPE  = 2'd0,
    CFG_OUTPUT_GAIN = 2'd1,
    CFG_RAMP_STEP   = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic tick;
    logic note_on;
    logic note_off;
    logic mul_first;
    logic mul_second;
    logic finish;
  } wto_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } wto_sts_t;

  typedef logic [SINE_DEPTH-1:0][15:0] sine_rom_t;

  // round(32767*sin(pi/2*i/QUARTER_LEN)) by a Q30 Taylor series.
  function automatic logic [15:0] quarter_sine(input logic [SINE_ADDR_BITS-1:0] idx);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x = ({{(64-SINE_ADDR_BITS){1'b0}}, idx} * HALF_PI_Q30) / QUARTER_LEN;
    term = x;
    sum = x;
    for (int k = 1; k <= 12; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'(TAYLOR_DIV[k]);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      t[i] = quarter_sine(SINE_ADDR_BITS'(i));
    end
    return t;
  endfunction

endpackage

// ===== hw/rtl/wto_sine_rom.sv =====
// Quarter-wave sine ROM with registered read.
// Depends on wto_pkg for the table contents and geometry.
`timescale 1ns / 1ps

module wto_sine_rom (
  input  logic                               clk_i,
  input  logic                               rd_en_i,
  input  logic [wto_pkg::SINE_ADDR_BITS-1:0] rd_addr_i,
  output logic [15:0]                        rd_data_o
);
  import wto_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= SINE_ROM[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/wto_datapath.sv =====
// Oscillator datapath: config registers, phase/envelope state, waveform
// shaping, shared multiplier, rounding/mix and the output register.
// Depends on wto_pkg and wto_sine_rom.
`timescale 1ns / 1ps

module wto_datapath #(
  parameter int PHASE_BITS  = wto_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = wto_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wto_pkg::wto_cmd_t               cmd_i,
  output wto_pkg::wto_sts_t               sts_o,
  input  logic [wto_pkg::IN_DATA_W-1:0]   in_data_i,
  input  logic                            cfg_we_i,
  input  logic [wto_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [wto_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [wto_pkg::OUT_W-1:0]       out_data_o
);
  import wto_pkg::*;

  localparam int MUL_A_W   = SAMPLE_BITS + GAIN_W;
  localparam int MUL_B_W   = ENV_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int OUT_SHIFT = SAMPLE_BITS + 15;
  localparam int OSC_W     = 17;
  localparam int SUM_W     = 18;
  localparam logic [SAMPLE_BITS-1:0] WAVE_ONE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX = 18'sd32767;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -18'sd32768;

  // Configuration
  shape_e              wave_shape_q;
  logic [GAIN_W-1:0]   output_gain_q;
  logic [ENV_W-1:0]    ramp_step_q;

  // Oscillator state
  logic [PHASE_BITS-1:0] phase_q, phase_d, phase_inc;
  logic [TUNING_W-1:0]   step_q;
  logic                  gate_q;
  logic [ENV_W-1:0]      env_q, env_d;
  logic [ENV_W:0]        env_sum;

  // Per-word working registers
  logic [SAMPLE_BITS-1:0] wave_mag_q, wave_mag_d;
  logic                   wave_sign_q, wave_sign_d;
  logic [MIX_W-1:0]       mix_q;
  logic [PROD_W-1:0]      prod_q;

  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_data_q, out_data_d;

  // Waveform terms
  logic [SINE_TABLE_BITS-1:0]  sine_p;
  logic [SINE_TABLE_BITS-3:0]  sine_j;
  logic [SINE_ADDR_BITS-1:0]   sine_idx;
  logic [15:0]                 rom_data;
  logic [SAMPLE_BITS-1:0]      sine_mag;
  logic [SAMPLE_BITS-1:0]      saw_t;
  logic [PHASE_BITS-1:0]       tri_d;
  logic [SAMPLE_BITS:0]        tri_u, tri_diff;
  logic                        tri_neg;

  logic [SAMPLE_BITS-1:0] mag_sel;
  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [PROD_W-1:0]      mul_p;
  logic [PROD_W-1:0]      rnd;
  logic [OSC_W-1:0]       osc_mag;
  logic signed [SUM_W-1:0] osc, mix_ext, mix_sum;

  // Phase increment: tuning word is a 32-bit fraction.
  if (PHASE_BITS <= TUNING_W) begin : g_inc_trunc
    assign phase_inc = step_q[TUNING_W-1 -: PHASE_BITS];
  end else begin : g_inc_ext
    assign phase_inc = {step_q, {(PHASE_BITS-TUNING_W){1'b0}}};
  end

  if (PHASE_BITS >= SAMPLE_BITS) begin : g_saw_trunc
    assign saw_t = phase_q[PHASE_BITS-1 -: SAMPLE_BITS];
  end else begin : g_saw_ext
    assign saw_t = {phase_q, {(SAMPLE_BITS-PHASE_BITS){1'b0}}};
  end

  if (PHASE_BITS >= SAMPLE_BITS + 1) begin : g_tri_trunc
    assign tri_u = tri_d[PHASE_BITS-1 -: SAMPLE_BITS+1];
  end else begin : g_tri_ext
    assign tri_u = {tri_d, {(SAMPLE_BITS+1-PHASE_BITS){1'b0}}};
  end

  if (SAMPLE_BITS <= 16) begin : g_sine_trunc
    assign sine_mag = rom_data[15 -: SAMPLE_BITS];
  end else begin : g_sine_ext
    assign sine_mag = {rom_data, {(SAMPLE_BITS-16){1'b0}}};
  end

  // Quarter-wave folding: odd quadrants mirror the index, upper half negates.
  assign sine_p   = phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign sine_j   = sine_p[SINE_TABLE_BITS-3:0];
  assign sine_idx = sine_p[SINE_TABLE_BITS-2] ? (QUARTER_IDX - {1'b0, sine_j})
                                              : {1'b0, sine_j};

  wto_sine_rom u_sine_rom (
    .clk_i     (clk_i),
    .rd_en_i   (cmd_i.tick),
    .rd_addr_i (sine_idx),
    .rd_data_o (rom_data)
  );

  assign tri_d    = phase_q[PHASE_BITS-1] ? (phase_q - {1'b1, {(PHASE_BITS-1){1'b0}}})
                                          : ({1'b1, {(PHASE_BITS-1){1'b0}}} - phase_q);
  assign tri_neg  = (tri_u < {1'b0, WAVE_ONE});
  assign tri_diff = tri_neg ? ({1'b0, WAVE_ONE} - tri_u) : (tri_u - {1'b0, WAVE_ONE});

  // Magnitude and sign of the waveform value; for sine only the sign.
  always_comb begin
    wave_mag_d  = '0;
    wave_sign_d = 1'b0;
    unique case (wave_shape_q)
      SHAPE_SINE: begin
        wave_sign_d = sine_p[SINE_TABLE_BITS-1];
      end
      SHAPE_SQUARE: begin
        wave_mag_d  = WAVE_ONE;
        wave_sign_d = phase_q[PHASE_BITS-1];
      end
      SHAPE_SAW: begin
        wave_sign_d = ~saw_t[SAMPLE_BITS-1];
        wave_mag_d  = saw_t[SAMPLE_BITS-1] ? (saw_t - WAVE_ONE) : (WAVE_ONE - saw_t);
      end
      SHAPE_TRI: begin
        wave_sign_d = tri_neg;
        wave_mag_d  = tri_diff[SAMPLE_BITS-1:0];
      end
      default: begin
        wave_mag_d  = '0;
        wave_sign_d = 1'b0;
      end
    endcase
  end

  // Envelope moves one step toward its target, clamped.
  always_comb begin
    env_sum = {1'b0, env_q} + {1'b0, ramp_step_q};
    if (gate_q) begin
      env_d = (env_sum > {1'b0, ENV_ONE}) ? ENV_ONE : env_sum[ENV_W-1:0];
    end else begin
      env_d = (env_q > ramp_step_q) ? (env_q - ramp_step_q) : '0;
    end
  end

  assign phase_d = phase_q + phase_inc;

  // Shared multiplier: |w|*gain, then that product times envelope.
  assign mag_sel = (wave_shape_q == SHAPE_SINE) ? sine_mag : wave_mag_q;
  assign mul_a   = cmd_i.mul_second ? prod_q[MUL_A_W-1:0] : {{GAIN_W{1'b0}}, mag_sel};
  assign mul_b   = cmd_i.mul_second ? env_q : {1'b0, output_gain_q};
  assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Round magnitude half away from zero, apply sign, mix and saturate.
  assign rnd     = prod_q + RND_HALF;
  assign osc_mag = rnd[OUT_SHIFT +: OSC_W];
  assign osc     = wave_sign_q ? -$signed({1'b0, osc_mag}) : $signed({1'b0, osc_mag});
  assign mix_ext = SUM_W'($signed(mix_q));
  assign mix_sum = mix_ext + osc;

  always_comb begin
    priority if (mix_sum > SAT_MAX) begin
      out_data_d = SAT_MAX[OUT_W-1:0];
    end else if (mix_sum < SAT_MIN) begin
      out_data_d = SAT_MIN[OUT_W-1:0];
    end else begin
      out_data_d = mix_sum[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_shape_q  <= SHAPE_SINE;
      output_gain_q <= GAIN_RESET;
      ramp_step_q   <= RAMP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WAVE_SHAPE:  wave_shape_q  <= shape_e'(cfg_data_i[1:0]);
        CFG_OUTPUT_GAIN: output_gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_RAMP_STEP:   ramp_step_q   <= cfg_data_i[ENV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
      gate_q  <= 1'b0;
      env_q   <= '0;
    end else begin
      if (cmd_i.note_on) begin
        step_q <= in_data_i[TUNING_W-1:0];
        gate_q <= 1'b1;
      end
      if (cmd_i.note_off) begin
        gate_q <= 1'b0;
      end
      if (cmd_i.tick) begin
        env_q   <= env_d;
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      wave_mag_q  <= wave_mag_d;
      wave_sign_q <= wave_sign_d;
      mix_q       <= in_data_i[IN_DATA_W-1:TUNING_W];
    end
    if (cmd_i.mul_first || cmd_i.mul_second) begin
      prod_q <= mul_p;
    end
    if (cmd_i.finish) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_blocked = out_valid_q & ~out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

  a_env_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= ENV_ONE)
    else $error("envelope above unity");

  a_phase_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != $past(phase_q)) |-> $past(cmd_i.tick))
    else $error("phase moved without a tick");

endmodule

// ===== hw/rtl/wto_ctrl.sv =====
// Oscillator controller: decodes input words and sequences the datapath
// through the two multiply steps and the output load. Depends on wto_pkg.
`timescale 1ns / 1ps

module wto_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [wto_pkg::ACTION_W-1:0] in_action_i,
  output logic                         in_ready_o,
  output wto_pkg::wto_cmd_t            cmd_o,
  input  wto_pkg::wto_sts_t            sts_i
);
  import wto_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL1 = 4'b0010,
    ST_MUL2 = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    cmd_o            = '0;
    cmd_o.tick       = accept && (in_action_i == ACT_TICK);
    cmd_o.note_on    = accept && (in_action_i == ACT_NOTE_ON);
    cmd_o.note_off   = accept && (in_action_i == ACT_NOTE_OFF);
    cmd_o.mul_first  = (state_q == ST_MUL1);
    cmd_o.mul_second = (state_q == ST_MUL2);
    cmd_o.finish     = (state_q == ST_DONE) && !sts_i.out_blocked;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_o.tick) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_DONE;
      ST_DONE: if (!sts_i.out_blocked) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_tick_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick |=> (state_q == ST_MUL1) ##1 (state_q == ST_MUL2))
    else $error("tick did not start the multiply sequence");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && sts_i.out_blocked) |=> (state_q == ST_DONE))
    else $error("left DONE while output register full");

endmodule

// ===== hw/rtl/wavetable_oscillator_with_ramp.sv =====
// Top level of the DDS oscillator with linear attack/release ramp.
// Depends on wto_pkg, wto_ctrl, wto_datapath (and wto_sine_rom below it).
//
// Usage:
//   s_axis: one word per action. tuser = action (tick, note on, note off),
//   tdata = tuning word (bits 31:0) and mix input sample (bits 47:32).
//   m_axis: one saturated 16-bit sample per tick word; note words and the
//   unused action code produce nothing.
//   cfg: index/data write port for wave shape, output gain and ramp step;
//   always ready; the user must write only while no tick is in flight (not enforced).
// Timing: a tick word runs through accept, gain multiply, envelope
//   multiply and round/mix/load, in that order; its result is loaded into
//   the output register in the last step. A note word is applied on its
//   acceptance. One multiplier is shared by both multiply steps, and no
//   new word is accepted until a tick has finished its last step.
// Reset clears phase, tuning step, envelope and gate and restores the
//   register defaults; the sine table is constant.
// Stall: the output register holds its word until taken; the next tick is
//   computed meanwhile and waits in its final step with s_axis_tready_o low.
`timescale 1ns / 1ps

module wavetable_oscillator_with_ramp #(
  parameter int PHASE_BITS  = wto_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = wto_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [wto_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,  // tuning_word[31:0], mix_in[47:32]
  input  logic [wto_pkg::ACTION_W-1:0]    s_axis_tuser_i,  // action[1:0]
  // Output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [wto_pkg::OUT_W-1:0]       m_axis_tdata_o,  // mixed_out[15:0]
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wto_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [wto_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import wto_pkg::*;

  wto_cmd_t cmd;
  wto_sts_t sts;

  assign cfg_ready_o = 1'b1;

  wto_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  wto_datapath #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
